>>> src/bas_pkg.sv
// Package for the bounded array set: transfer payload types, operation codes,
// controller states and the per-cell control group. No dependencies.
`default_nettype none
package bas_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_CLEAR  = 2'd3
  } bas_mode_t;

  typedef struct packed {
    bas_mode_t   mode;
    logic [31:0] element;
  } bas_in_t;

  typedef struct packed {
    logic       was_present;
    logic       changed;
    logic       full_drop;
    logic [7:0] member_count;
  } bas_out_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } bas_state_t;

  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } bas_ctl_t;

endpackage
`default_nettype wire

>>> src/bas_cell.sv
// One storage cell of the set chain: holds one entry, compares it against the operand,
// passes the found flag up, takes the operand on insert if it is the first free cell,
// and takes its upper neighbour's entry on removal. Depends on bas_pkg.
`default_nettype none
module bas_cell import bas_pkg::*; #(
  parameter int IDX = 0,
  parameter int EW  = 32,
  parameter int CW  = 8
) (
  input  wire logic          clk,
  input  wire bas_ctl_t      ctl,
  input  wire logic [EW-1:0] elem,
  input  wire logic [CW-1:0] count,
  input  wire logic [EW-1:0] next_entry,
  input  wire logic          seen_in,
  output logic               seen_out,
  output logic [EW-1:0]      entry
);

  logic [EW-1:0] entry_r;
  logic [EW-1:0] entry_nxt;
  logic          occupied;
  logic          match;

  assign occupied = count > CW'(IDX);
  assign match    = occupied && (entry_r == elem);
  assign seen_out = seen_in | match;
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en && (count == CW'(IDX))) begin
      entry_nxt = elem;
    end else if (ctl.rem_en && seen_out) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule
`default_nettype wire

>>> src/bounded_array_set.sv
// Bounded array set: a chain of CAPACITY entry cells with a count, in insertion order.
// Operation: the input transfer is captured, then an execute state compares all cells,
// ripples the found flag along the chain and updates; the result is registered.
// A new item is accepted only when idle and no stalled result is still held.
// Reset: count cleared to an empty set, no result pending; entry contents undefined.
`default_nettype none
module bounded_array_set import bas_pkg::*; #(
  parameter int CAPACITY      = 128,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire bas_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output bas_out_t      out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ELEMENT_WIDTH;

  bas_state_t    state_r, state_nxt;
  bas_mode_t     mode_r;
  logic [EW-1:0] elem_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  bas_out_t      out_data_r, out_data_nxt;

  logic          in_xfer;
  logic          present;
  logic          full;
  bas_ctl_t      ctl;
  logic [CW+7:0] count_wide;

  logic [CAPACITY:0]   seen;
  logic [EW-1:0]       ent [CAPACITY+1];

  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_xfer  = in_valid && !in_stall;
  assign present  = seen[CAPACITY];
  assign full     = (count_r == CW'(CAPACITY));

  assign seen[0]       = 1'b0;
  assign ent[CAPACITY] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    bas_cell #(
      .IDX (i),
      .EW  (EW),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .elem       (elem_r),
      .count      (count_r),
      .next_entry (ent[i+1]),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .entry      (ent[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ctl           = '0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt                = ST_IDLE;
        out_valid_nxt            = 1'b1;
        out_data_nxt.was_present = present;
        out_data_nxt.changed     = 1'b0;
        out_data_nxt.full_drop   = 1'b0;
        case (mode_r)
          MODE_INSERT: begin
            if (!present) begin
              if (full) begin
                out_data_nxt.full_drop = 1'b1;
              end else begin
                ctl.ins_en           = 1'b1;
                count_nxt            = count_r + CW'(1);
                out_data_nxt.changed = 1'b1;
              end
            end
          end
          MODE_REMOVE: begin
            ctl.rem_en = 1'b1;
            if (present) begin
              count_nxt            = count_r - CW'(1);
              out_data_nxt.changed = 1'b1;
            end
          end
          MODE_QUERY: begin
          end
          MODE_CLEAR: begin
            out_data_nxt.changed = (count_r != '0);
            count_nxt            = '0;
          end
          default: begin
          end
        endcase
        out_data_nxt.member_count = count_wide[7:0];
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign count_wide = {8'b0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_xfer) begin
      mode_r <= in_data.mode;
      elem_r <= EW'(in_data.element);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

>>> verif/bounded_array_set_tb.sv
// Self-checking testbench for bounded_array_set: a directed table, then random
// insert/remove/query/clear traffic with fills to capacity, under random idling.
// Depends on bas_pkg and the bounded_array_set RTL.
`default_nettype none
module bounded_array_set_tb;
  import bas_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SET_CAPACITY = 128;
  localparam int HOLD_CYCLES  = 80;

  typedef struct {
    bas_in_t  item;
    bit       fixed;
    bas_out_t result;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  bas_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  bas_out_t out_data;

  logic [31:0] set_entries [SET_CAPACITY];
  int          set_size = 0;
  bas_out_t    pending_results [$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_requests = 0;
  logic [31:0] fill_base = '0;
  logic [31:0] elem_pool [24];

  stim_row_t directed_rows [16] = '{
    '{'{MODE_QUERY,  32'h0000_0000}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd0}},
    '{'{MODE_REMOVE, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd0}},
    '{'{MODE_CLEAR,  32'h0000_0005}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd0}},
    '{'{MODE_INSERT, 32'h0000_0000}, 1'b1, '{1'b0, 1'b1, 1'b0, 8'd1}},
    '{'{MODE_INSERT, 32'hFFFF_FFFF}, 1'b1, '{1'b0, 1'b1, 1'b0, 8'd2}},
    '{'{MODE_INSERT, 32'h0000_0000}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd2}},
    '{'{MODE_QUERY,  32'hFFFF_FFFF}, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd2}},
    '{'{MODE_INSERT, 32'h5555_5555}, 1'b0, '0},
    '{'{MODE_INSERT, 32'hAAAA_AAAA}, 1'b0, '0},
    '{'{MODE_REMOVE, 32'h0000_0000}, 1'b0, '0},
    '{'{MODE_QUERY,  32'h5555_5555}, 1'b0, '0},
    '{'{MODE_REMOVE, 32'h0000_0000}, 1'b0, '0},
    '{'{MODE_REMOVE, 32'hAAAA_AAAA}, 1'b0, '0},
    '{'{MODE_INSERT, 32'h0000_0000}, 1'b0, '0},
    '{'{MODE_CLEAR,  32'hFFFF_FFFF}, 1'b1, '{1'b1, 1'b1, 1'b0, 8'd0}},
    '{'{MODE_CLEAR,  32'h0000_0000}, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd0}}
  };

  bounded_array_set #(
    .CAPACITY      (SET_CAPACITY),
    .ELEMENT_WIDTH (32)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic bas_out_t apply_set_op(bas_in_t item);
    bas_out_t r;
    int pos;
    int i;
    r = '0;
    pos = set_size;
    for (i = set_size - 1; i >= 0; i--) begin
      if (set_entries[i] == item.element) pos = i;
    end
    r.was_present = (pos < set_size);
    case (item.mode)
      MODE_INSERT: begin
        if (!r.was_present) begin
          if (set_size < SET_CAPACITY) begin
            set_entries[set_size] = item.element;
            set_size++;
            r.changed = 1'b1;
          end else begin
            r.full_drop = 1'b1;
          end
        end
      end
      MODE_REMOVE: begin
        if (r.was_present) begin
          for (i = pos; i < set_size - 1; i++) set_entries[i] = set_entries[i + 1];
          set_size--;
          r.changed = 1'b1;
        end
      end
      MODE_QUERY: begin
      end
      default: begin
        r.changed = (set_size != 0);
        set_size = 0;
      end
    endcase
    r.member_count = 8'(set_size);
    return r;
  endfunction

  // One input transfer; the expectation is queued at the accepting edge.
  task automatic send_item(input bas_in_t item, input bit fixed, input bas_out_t fixed_res);
    bas_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = apply_set_op(item);
    pending_results.push_back(fixed ? fixed_res : predicted);
  endtask

  task automatic send_op(input bas_mode_t mode, input logic [31:0] element);
    bas_in_t item;
    item.mode    = mode;
    item.element = element;
    send_item(item, 1'b0, '0);
  endtask

  task automatic random_op();
    bas_mode_t mode;
    logic [31:0] element;
    int r;
    int k;
    r = $urandom_range(99);
    mode = (r < 45) ? MODE_INSERT : (r < 70) ? MODE_REMOVE : (r < 97) ? MODE_QUERY : MODE_CLEAR;
    k = $urandom_range(19);
    if (k < 11) element = elem_pool[$urandom_range(23)];
    else if (k < 15) element = fill_base ^ 32'($urandom_range(159));
    else if (k == 15) element = 32'h0000_0000;
    else if (k == 16) element = 32'hFFFF_FFFF;
    else element = $urandom;
    send_op(mode, element);
  endtask

  // Clear, insert distinct values up to capacity, then work at the full boundary.
  task automatic fill_to_capacity();
    int i;
    fill_base = $urandom;
    send_op(MODE_CLEAR, fill_base);
    for (i = 0; i < SET_CAPACITY; i++) send_op(MODE_INSERT, fill_base ^ 32'(i));
    for (i = 0; i < 3; i++) send_op(MODE_INSERT, fill_base ^ 32'(200 + i));
    send_op(MODE_INSERT, fill_base ^ 32'($urandom_range(SET_CAPACITY - 1)));
    send_op(MODE_QUERY, fill_base ^ 32'(SET_CAPACITY - 1));
    send_op(MODE_REMOVE, fill_base);
    send_op(MODE_INSERT, fill_base ^ 32'd300);
    send_op(MODE_INSERT, fill_base ^ 32'd301);
    send_op(MODE_REMOVE, fill_base ^ 32'($urandom_range(1, SET_CAPACITY - 1)));
    send_op(MODE_REMOVE, fill_base ^ 32'd300);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input bit long_hold);
    int i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (i = 0; i < 24; i++) elem_pool[i] = $urandom;
    for (i = 0; i < 60; i++) random_op();
    fill_to_capacity();
    for (i = 0; i < 40; i++) begin
      if (long_hold && i == 5) hold_requests++;
      random_op();
    end
    // sender pauses until the block has drained
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input bas_out_t got);
    bas_out_t exp;
    if (pending_results.size() == 0) begin
      $error("unexpected result transfer: %p", got);
      fail_count++;
    end else begin
      exp = pending_results.pop_front();
      if (got.was_present !== exp.was_present) begin
        $error("was_present: expected %0d, got %0d", exp.was_present, got.was_present);
        fail_count++;
      end
      if (got.changed !== exp.changed) begin
        $error("changed: expected %0d, got %0d", exp.changed, got.changed);
        fail_count++;
      end
      if (got.full_drop !== exp.full_drop) begin
        $error("full_drop: expected %0d, got %0d", exp.full_drop, got.full_drop);
        fail_count++;
      end
      if (got.member_count !== exp.member_count) begin
        $error("member_count: expected %0d, got %0d", exp.member_count, got.member_count);
        fail_count++;
      end
    end
  endtask

  initial begin : result_side
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) check_result(out_data);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int i;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 9;
    recv_idle_pct = 50;
    for (i = 0; i < 16; i++) begin
      send_item(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].result);
    end
    run_phase(9, 50, 1'b0);
    run_phase(50, 9, 1'b0);
    run_phase(0, 0, 1'b1);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("bounded_array_set test passed");
    end else begin
      $display("bounded_array_set test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("bounded_array_set test failed");
    $finish;
  end

endmodule
`default_nettype wire

>>> files.f
src/bas_pkg.sv
src/bas_cell.sv
src/bounded_array_set.sv
verif/bounded_array_set_tb.sv
